[rtl/assert_macros.svh]
// Assertion macros used by the checker file mavg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/mavg_pkg.sv]
package mavg_pkg;

    // Width of the window length register.
    localparam int WIN_REG_W = 5;

    // Window length after reset.
    localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 5'd10;

endpackage

[rtl/moving_average_filter.sv]
// Boxcar moving-average filter with a bit-serial restoring divider.
// A sample goes through S_SUM, S_DIV and S_DONE to output valid; a clear goes to S_DONE.
// S_DIV divides |sum| (SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) + 1, 21 at default sizes).
// Items are taken only once the last one is through; the divider shifts one quotient bit per
// cycle, and a waiting result holds the next item at its end.
// Reset (async, active low): empty window, window_length = 10, no output pending.
module moving_average_filter
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [WIN_REG_W-1:0]          cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          clear,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] mean
);

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int CNT_W  = $clog2(SUM_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [WIN_REG_W-1:0]     window_length_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SLOT_W-1:0]        write_slot_reg;
    logic [LEN_W-1:0]         fill_count_reg;
    logic                     window_full_reg;
    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   mean_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic [SAMPLE_BITS-1:0]   old_reg;
    logic [SUM_W-1:0]         div_reg;
    logic [LEN_W-1:0]         rem_reg;
    logic [LEN_W-1:0]         divisor_reg;
    logic                     neg_reg;
    logic [CNT_W-1:0]         bit_cnt_reg;

    logic [SAMPLE_BITS-1:0]   ring [MAX_WINDOW];

    logic [LEN_W-1:0]         eff_len;
    logic [SLOT_W-1:0]        slot_start;
    logic [SLOT_W-1:0]        slot_after;
    logic [LEN_W-1:0]         slot_inc;
    logic signed [SUM_W-1:0]  x_ext;
    logic signed [SUM_W-1:0]  old_ext;
    logic signed [SUM_W-1:0]  sum_new;
    logic [SUM_W-1:0]         sum_abs;
    logic [LEN_W-1:0]         fill_inc;
    logic                     fill_done;
    logic [LEN_W-1:0]         divisor_new;
    logic [LEN_W:0]           rem_shift;
    logic                     q_bit;
    logic [LEN_W-1:0]         rem_next;
    logic [SAMPLE_BITS-1:0]   q_low;
    logic [SAMPLE_BITS-1:0]   avg_signed;
    logic                     in_accept;

    // Handshakes: config and items are taken only between items.
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;

    // Clamp the window length to 1..MAX_WINDOW.
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (int'(window_length_reg) > MAX_WINDOW)
        begin
            eff_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = LEN_W'(window_length_reg);
        end
    end

    // Pick the ring slot for this item and the one after it.
    assign slot_start = (LEN_W'(write_slot_reg) >= eff_len) ? '0 : write_slot_reg;
    assign slot_inc   = LEN_W'(slot_reg) + LEN_W'(1);
    assign slot_after = (slot_inc >= eff_len) ? '0 : SLOT_W'(slot_inc);

    // Update the running sum and the fill state.
    assign x_ext    = {{(SUM_W - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign old_ext  = {{(SUM_W - SAMPLE_BITS){old_reg[SAMPLE_BITS-1]}}, old_reg};
    assign sum_new  = window_full_reg ? (sum_reg - old_ext + x_ext) : (sum_reg + x_ext);
    assign sum_abs  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
    assign fill_inc = fill_count_reg + LEN_W'(1);
    assign fill_done = window_full_reg || (fill_inc >= eff_len);
    assign divisor_new = fill_done ? eff_len : fill_inc;

    // One restoring-division step on the magnitude.
    assign rem_shift = {rem_reg, div_reg[SUM_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, divisor_reg});
    assign rem_next  = q_bit ? LEN_W'(rem_shift - {1'b0, divisor_reg}) : LEN_W'(rem_shift);

    // Restore the sign of the quotient.
    assign q_low      = div_reg[SAMPLE_BITS-1:0];
    assign avg_signed = neg_reg ? (~q_low + SAMPLE_BITS'(1)) : q_low;

    // Sequence one item and hold the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            window_length_reg <= WINDOW_RESET;
            sum_reg           <= '0;
            write_slot_reg    <= '0;
            fill_count_reg    <= '0;
            window_full_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            mean_reg          <= '0;
            slot_reg          <= '0;
            sample_reg        <= '0;
            div_reg           <= '0;
            rem_reg           <= '0;
            divisor_reg       <= '0;
            neg_reg           <= 1'b0;
            bit_cnt_reg       <= '0;
        end
        else
        begin
            // Drop valid once the result is taken, unless a new one loads now.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        // Store the new length and empty the window.
                        window_length_reg <= cfg_data;
                        sum_reg           <= '0;
                        write_slot_reg    <= '0;
                        fill_count_reg    <= '0;
                        window_full_reg   <= 1'b0;
                    end
                    else if (in_valid)
                    begin
                        if (clear)
                        begin
                            // Empty the window and return zero.
                            sum_reg         <= '0;
                            write_slot_reg  <= '0;
                            fill_count_reg  <= '0;
                            window_full_reg <= 1'b0;
                            div_reg         <= '0;
                            neg_reg         <= 1'b0;
                            state_reg       <= S_DONE;
                        end
                        else
                        begin
                            sample_reg <= sample;
                            slot_reg   <= slot_start;
                            state_reg  <= S_SUM;
                        end
                    end
                end

                S_SUM:
                begin
                    sum_reg        <= sum_new;
                    write_slot_reg <= slot_after;
                    if (!window_full_reg)
                    begin
                        fill_count_reg  <= divisor_new;
                        window_full_reg <= fill_done;
                    end
                    divisor_reg <= divisor_new;
                    div_reg     <= sum_abs;
                    neg_reg     <= sum_new[SUM_W-1];
                    rem_reg     <= '0;
                    bit_cnt_reg <= CNT_W'(SUM_W - 1);
                    state_reg   <= S_DIV;
                end

                S_DIV:
                begin
                    // Shift in one quotient bit per cycle.
                    rem_reg <= rem_next;
                    div_reg <= {div_reg[SUM_W-2:0], q_bit};
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - CNT_W'(1);
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        mean_reg      <= avg_signed;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Sample ring: write the new sample, read the entry it replaces.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM)
        begin
            ring[slot_reg] <= sample_reg;
        end
        if (in_accept)
        begin
            old_reg <= ring[slot_start];
        end
    end

endmodule

[rtl/mavg_checker.sv]
`include "assert_macros.svh"

module mavg_checker
    import mavg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [WIN_REG_W-1:0]          cfg_data,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic                          clear,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] mean
);

    // Hold a stalled result.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mean))

    // Take no second item right after one is taken.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // Take items only when config writes are also open.
    `ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, cfg_ready)

    // Raise a result only after a busy cycle.
    `ASSERT_IMP(a_result_after_work, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind moving_average_filter mavg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mavg_checker (.*);
